@@ rtl/core/assert_macros.svh @@
// Assertion macros for the top level of the power block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge, off during reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition that must never hold at a rising clock edge, off during reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

@@ rtl/core/ips_pkg.sv @@
// Package with command and status types shared by the power block modules.
package ips_pkg;

    // Commands from the controller to the datapath, at most one per cycle
    typedef struct packed {
        logic load;   // capture a new item and set up base, exponent, accumulator
        logic mul;    // form and register the partial products
        logic acc;    // sum partial products, update base, accumulator, exponent
        logic fin;    // capture the final result into the output registers
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic exp_zero;   // remaining exponent is zero
        logic exp_last;   // remaining exponent has only its lowest bit left
    } t_dp_sts;

endpackage

@@ rtl/core/ips_ctrl.sv @@
// Controller state machine that sequences the square-and-multiply datapath.
module ips_ctrl
    import ips_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TEST,
        S_MUL,
        S_ACC,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign out_free    = !r_out_valid || i_out_ready;

    // Decode next state and datapath commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_TEST;
                end
            end
            S_TEST: begin
                n_state = i_sts.exp_zero ? S_FIN : S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_sts.exp_last ? S_FIN : S_MUL;
            end
            S_FIN: begin
                // hold the result until the output register is free
                if (out_free) begin
                    o_cmd.fin   = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ rtl/core/ips_datapath.sv @@
// Datapath with base, exponent and accumulator registers and split multipliers.
module ips_datapath
    import ips_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  t_dp_cmd               i_cmd,
    input  logic [DATA_WIDTH-1:0] i_base_value,
    input  logic [DATA_WIDTH-1:0] i_power,
    output t_dp_sts               o_sts,
    output logic [DATA_WIDTH-1:0] o_value,
    output logic                  o_divide_by_zero
);

    localparam int DW = DATA_WIDTH;
    localparam int H  = (DW + 1) / 2;   // low half width
    localparam int PW = 2 * H;          // partial product width

    logic [DW-1:0] r_base;
    logic [DW-1:0] r_acc;
    logic [DW-1:0] r_exp;
    logic          r_neg;
    logic [PW-1:0] r_sq_ll;
    logic [PW-1:0] r_sq_lh;
    logic [PW-1:0] r_mu_ll;
    logic [PW-1:0] r_mu_lh;
    logic [PW-1:0] r_mu_hl;
    logic [DW-1:0] r_value;
    logic          r_dz;

    logic [H-1:0]  b_lo;
    logic [H-1:0]  b_hi;
    logic [H-1:0]  a_lo;
    logic [H-1:0]  a_hi;
    logic [DW-1:0] e_abs;
    logic [DW-1:0] sq_sum;
    logic [DW-1:0] mu_sum;
    logic [DW-1:0] fin_value;
    logic          fin_dz;

    // Split base and accumulator into halves
    assign b_lo = r_base[H-1:0];
    assign b_hi = H'(r_base[DW-1:H]);
    assign a_lo = r_acc[H-1:0];
    assign a_hi = H'(r_acc[DW-1:H]);

    // Magnitude of the exponent; the most negative value stays negative and skips the loop
    assign e_abs = i_power[DW-1] ? (DW'(0) - i_power) : i_power;

    // Low words of the square and of the product, from registered partial products
    assign sq_sum = r_sq_ll[DW-1:0] + (r_sq_lh[DW-1:0] << (H + 1));
    assign mu_sum = r_mu_ll[DW-1:0] + (r_mu_lh[DW-1:0] << H) + (r_mu_hl[DW-1:0] << H);

    // Reciprocal step for a negative exponent
    always_comb begin
        fin_value = r_acc;
        fin_dz    = 1'b0;
        if (r_neg) begin
            if (r_acc == DW'(1) || (&r_acc)) begin
                fin_value = r_acc;
            end else begin
                fin_value = '0;
                fin_dz    = (r_acc == '0);
            end
        end
    end

    // Load, multiply and update the working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_base <= i_base_value;
            r_acc  <= DW'(1);
            r_neg  <= i_power[DW-1];
            r_exp  <= e_abs[DW-1] ? '0 : e_abs;
        end
        if (i_cmd.mul) begin
            r_sq_ll <= PW'(b_lo) * PW'(b_lo);
            r_sq_lh <= PW'(b_lo) * PW'(b_hi);
            r_mu_ll <= PW'(a_lo) * PW'(b_lo);
            r_mu_lh <= PW'(a_lo) * PW'(b_hi);
            r_mu_hl <= PW'(a_hi) * PW'(b_lo);
        end
        if (i_cmd.acc) begin
            r_base <= sq_sum;
            if (r_exp[0]) begin
                r_acc <= mu_sum;
            end
            r_exp <= r_exp >> 1;
        end
        if (i_cmd.fin) begin
            r_value <= fin_value;
            r_dz    <= fin_dz;
        end
    end

    assign o_sts.exp_zero  = (r_exp == '0);
    assign o_sts.exp_last  = (r_exp[DW-1:1] == '0);
    assign o_value          = r_value;
    assign o_divide_by_zero = r_dz;

endmodule

@@ rtl/core/integer_power_by_squaring.sv @@
// Top level of the integer power block: controller, datapath and checks.
//
// Raises a signed base to a signed exponent by square-and-multiply,
// products wrapping modulo 2^DATA_WIDTH; a negative exponent yields the
// truncated reciprocal and flags divide-by-zero when the power wraps to zero.
// Input channel: i_in_valid / o_in_ready with i_base_value and i_power.
// Output channel: o_out_valid / i_out_ready with o_value and o_divide_by_zero.
// One item is worked on at a time. Each exponent bit up to the highest set
// bit of its magnitude goes through the shared split multipliers in a
// partial-product step and then a sum step; a zero exponent skips the loop.
// The result sits in an output register, so a new item is accepted while the
// previous result waits; if the receiver stalls, the finished item holds in
// the controller until the output register frees.
// Reset (synchronous, active low) drops any item in flight and clears valid.
`include "assert_macros.svh"

module integer_power_by_squaring
    import ips_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [DATA_WIDTH-1:0] i_base_value,
    input  logic signed [DATA_WIDTH-1:0] i_power,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [DATA_WIDTH-1:0] o_value,
    output logic                         o_divide_by_zero
);

    t_dp_cmd               w_cmd;
    t_dp_sts               w_sts;
    logic [DATA_WIDTH-1:0] w_value;

    // Sequence the item
    ips_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Compute the power
    ips_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_cmd            (w_cmd),
        .i_base_value     (i_base_value),
        .i_power          (i_power),
        .o_sts            (w_sts),
        .o_value          (w_value),
        .o_divide_by_zero (o_divide_by_zero)
    );

    assign o_value = signed'(w_value);

    // Check controller and datapath consistency
    `ASSERT_CLK(a_busy_after_accept, (i_in_valid && o_in_ready) |=> !o_in_ready, "accepted item did not block the input")
    `ASSERT_CLK(a_fin_needs_room, w_cmd.fin |-> (!o_out_valid || i_out_ready), "result overwrote a waiting item")
    `ASSERT_CLK(a_one_cmd, $onehot0(w_cmd), "more than one datapath command in a cycle")
    `ASSERT_CLK(a_dz_zero_value, (o_out_valid && o_divide_by_zero) |-> (o_value == '0), "divide flag with a nonzero value")

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the integer power block with random handshake gaps.
module testbench;

    localparam int DW = 32;
    localparam logic TYPED = 1'b1;
    localparam logic PREDICTED = 1'b0;
    localparam int NUM_DIRECTED = 25;
    localparam int NUM_RANDOM = 1400;
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        logic [DW-1:0] base_value;
        logic [DW-1:0] power;
        logic          source;
        logic [DW-1:0] value;
        logic          divide_by_zero;
    } t_vector;

    typedef struct packed {
        logic [DW-1:0] base_value;
        logic [DW-1:0] power;
        logic [DW-1:0] value;
        logic          divide_by_zero;
    } t_power_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic signed [DW-1:0] i_base_value;
    logic signed [DW-1:0] i_power;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic signed [DW-1:0] o_value;
    logic                 o_divide_by_zero;

    t_power_result pending_powers[$];
    t_vector       directed_vectors[NUM_DIRECTED];
    int            mismatch_count = 0;
    logic          calm = 1'b0;

    integer_power_by_squaring #(
        .DATA_WIDTH(DW)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_base_value    (i_base_value),
        .i_power         (i_power),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_value         (o_value),
        .o_divide_by_zero(o_divide_by_zero)
    );

    // Square-and-multiply with wrapping products; reciprocal for negative exponents
    function automatic t_power_result predict_power(logic [DW-1:0] b, logic [DW-1:0] e);
        t_power_result r;
        logic [DW-1:0] acc;
        logic [DW-1:0] sq;
        logic [DW-1:0] mag;
        logic          neg;
        r.base_value = b;
        r.power = e;
        r.divide_by_zero = 1'b0;
        if (e == '0) begin
            r.value = 1;
            return r;
        end
        acc = 1;
        sq = b;
        neg = e[DW-1];
        mag = neg ? -e : e;
        // most negative exponent stays negative after negation: skip the loop
        if (!mag[DW-1]) begin
            while (mag != '0) begin
                if (mag[0]) acc = acc * sq;
                sq = sq * sq;
                mag = mag >> 1;
            end
        end
        if (!neg) begin
            r.value = acc;
        end else if (acc == 1 || acc == '1) begin
            r.value = acc;
        end else begin
            r.value = '0;
            r.divide_by_zero = (acc == '0);
        end
        return r;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Present one item, hold it until accepted, then record its expected result
    task automatic offer_item(input logic [DW-1:0] b, input logic [DW-1:0] p,
                              input logic src, input logic [DW-1:0] tv,
                              input logic tdz);
        int gap;
        t_power_result exp_res;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_base_value <= b;
        i_power <= p;
        do @(posedge i_clk); while (!o_in_ready);
        if (src == TYPED) begin
            exp_res.base_value = b;
            exp_res.power = p;
            exp_res.value = tv;
            exp_res.divide_by_zero = tdz;
        end else begin
            exp_res = predict_power(b, p);
        end
        pending_powers.push_back(exp_res);
    endtask

    // Generate the clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Stop a hung run
    initial begin
        #20000000;
        $display("Some tests failed");
        $finish;
    end

    // Drive reset, the directed table, then random items, and report
    initial begin
        logic [DW-1:0] b;
        logic [DW-1:0] p;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_base_value <= '0;
        i_power <= '0;
        directed_vectors = '{
            '{32'h0000_0000, 32'h0000_0000, TYPED,     32'h0000_0001, 1'b0},
            '{32'h8000_0000, 32'h0000_0000, TYPED,     32'h0000_0001, 1'b0},
            '{32'h7fff_ffff, 32'h7fff_ffff, PREDICTED, 32'h0000_0000, 1'b0},
            '{32'hffff_ffff, 32'h7fff_ffff, TYPED,     32'hffff_ffff, 1'b0},
            '{32'hffff_ffff, 32'h8000_0000, TYPED,     32'h0000_0001, 1'b0},
            '{32'h0000_0000, 32'h8000_0000, TYPED,     32'h0000_0001, 1'b0},
            '{32'h0000_0000, 32'hffff_ffff, TYPED,     32'h0000_0000, 1'b1},
            '{32'h0000_0002, 32'hffff_ffe0, TYPED,     32'h0000_0000, 1'b1},
            '{32'h0000_0002, 32'hffff_ffff, TYPED,     32'h0000_0000, 1'b0},
            '{32'h0000_0001, 32'h8000_0001, TYPED,     32'h0000_0001, 1'b0},
            '{32'hffff_ffff, 32'hffff_fffd, TYPED,     32'hffff_ffff, 1'b0},
            '{32'hffff_ffff, 32'hffff_fffe, TYPED,     32'h0000_0001, 1'b0},
            '{32'h0000_0002, 32'h0000_001f, TYPED,     32'h8000_0000, 1'b0},
            '{32'h0000_0002, 32'h0000_0020, TYPED,     32'h0000_0000, 1'b0},
            '{32'h8000_0000, 32'h0000_0001, TYPED,     32'h8000_0000, 1'b0},
            '{32'h8000_0000, 32'h0000_0002, TYPED,     32'h0000_0000, 1'b0},
            '{32'h7fff_ffff, 32'h0000_0002, TYPED,     32'h0000_0001, 1'b0},
            '{32'h0000_0000, 32'h0000_0005, TYPED,     32'h0000_0000, 1'b0},
            '{32'h0000_0003, 32'h0000_0004, PREDICTED, 32'h0000_0000, 1'b0},
            '{32'hffff_fffd, 32'h0000_0003, PREDICTED, 32'h0000_0000, 1'b0},
            '{32'h0001_e240, 32'hffff_ffff, TYPED,     32'h0000_0000, 1'b0},
            '{32'h0000_0003, 32'h7fff_ffff, PREDICTED, 32'h0000_0000, 1'b0},
            '{32'h1234_5678, 32'h0000_ffff, PREDICTED, 32'h0000_0000, 1'b0},
            '{32'h8000_0000, 32'hffff_ffff, TYPED,     32'h0000_0000, 1'b0},
            '{32'h7fff_ffff, 32'hffff_fffe, TYPED,     32'h0000_0001, 1'b0}
        };
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            offer_item(directed_vectors[i].base_value, directed_vectors[i].power,
                       directed_vectors[i].source, directed_vectors[i].value,
                       directed_vectors[i].divide_by_zero);
        end

        // Random items, biased toward small, extreme and power-of-two values
        for (int i = 0; i < NUM_RANDOM; i++) begin
            calm = (i >= 500 && i < 700);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: b = $urandom_range(0, 16) - 8;
                4: begin
                    b = 32'd1 << $urandom_range(0, DW - 1);
                    if ($urandom_range(0, 1) != 0) b = -b;
                end
                5: case ($urandom_range(0, 4))
                    0: b = 32'h0000_0000;
                    1: b = 32'h0000_0001;
                    2: b = 32'hffff_ffff;
                    3: b = 32'h8000_0000;
                    default: b = 32'h7fff_ffff;
                endcase
                default: b = $urandom;
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3: p = $urandom_range(0, 40);
                4, 5: p = -$urandom_range(1, 40);
                6: case ($urandom_range(0, 5))
                    0: p = 32'h0000_0000;
                    1: p = 32'h0000_0001;
                    2: p = 32'hffff_ffff;
                    3: p = 32'h8000_0000;
                    4: p = 32'h7fff_ffff;
                    default: p = 32'h8000_0001;
                endcase
                default: p = $urandom;
            endcase
            offer_item(b, p, PREDICTED, '0, 1'b0);
        end
        i_in_valid <= 1'b0;
        calm = 1'b0;

        // Drain outstanding results, then watch for strays
        while (pending_powers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Accept results with random stalls and compare against the oldest expectation
    initial begin
        t_power_result exp_res;
        int stall_left;
        logic ready_next;
        stall_left = 0;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                if (pending_powers.size() == 0) begin
                    $display("%0t: result with no item pending: value %h, divide_by_zero %b",
                             $time, o_value, o_divide_by_zero);
                    mismatch_count++;
                end else begin
                    exp_res = pending_powers.pop_front();
                    if (o_value !== exp_res.value) begin
                        $display("%0t: value for base %h power %h: expected %h, actual %h",
                                 $time, exp_res.base_value, exp_res.power,
                                 exp_res.value, o_value);
                        mismatch_count++;
                    end
                    if (o_divide_by_zero !== exp_res.divide_by_zero) begin
                        $display("%0t: divide_by_zero for base %h power %h: expected %b, actual %b",
                                 $time, exp_res.base_value, exp_res.power,
                                 exp_res.divide_by_zero, o_divide_by_zero);
                        mismatch_count++;
                    end
                end
            end
            // Hold off for a random stretch now and then
            if (stall_left != 0) begin
                stall_left--;
                ready_next = (stall_left == 0);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap() + 1;
                ready_next = 1'b0;
            end else begin
                ready_next = 1'b1;
            end
            i_out_ready <= ready_next;
        end
    end

endmodule
